/* src/battery_tier_rate_governor_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef BATTERY_TIER_RATE_GOVERNOR_TOP_DEFINES_SVH
`define BATTERY_TIER_RATE_GOVERNOR_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BTRG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define BTRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/btrg_pkg.sv */
package btrg_pkg;

  // Command codes of the request word; code 3 is a no-op.
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_FORCE_EVAL = 2'd1,
    CMD_EVENT      = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BATT_HIGH_THRESHOLD = 3'd0,
    REG_BATT_MED_THRESHOLD  = 3'd1,
    REG_GPS_PERIOD_HIGH     = 3'd2,
    REG_GPS_PERIOD_MED      = 3'd3,
    REG_GPS_PERIOD_LOW      = 3'd4,
    REG_PPG_PERIOD_HIGH     = 3'd5,
    REG_PPG_PERIOD_LOW      = 3'd6,
    REG_EVALUATION_PERIOD   = 3'd7
  } reg_index_t;

  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned PeriodWidth  = 16;
  localparam int unsigned PctWidth     = 7;
  localparam int unsigned TierWidth    = 2;

  // Tier codes.
  localparam logic [TierWidth-1:0] TierHigh = 2'd0;
  localparam logic [TierWidth-1:0] TierMed  = 2'd1;
  localparam logic [TierWidth-1:0] TierLow  = 2'd2;

  // Clamp defaults.
  localparam int unsigned GpsMinPeriodDefault = 1;
  localparam int unsigned PpgMaxPeriodDefault = 3600;

  // Reset values.
  localparam logic [PctWidth-1:0]    RstBattHigh  = 7'd60;
  localparam logic [PctWidth-1:0]    RstBattMed   = 7'd20;
  localparam logic [PeriodWidth-1:0] RstGpsHigh   = 16'd10;
  localparam logic [PeriodWidth-1:0] RstGpsMed    = 16'd60;
  localparam logic [PeriodWidth-1:0] RstGpsLow    = 16'd300;
  localparam logic [PeriodWidth-1:0] RstPpgHigh   = 16'd1;
  localparam logic [PeriodWidth-1:0] RstPpgLow    = 16'd10;
  localparam logic [PeriodWidth-1:0] RstEvalPer   = 16'd60;
  localparam logic [PctWidth-1:0]    RstLevel     = 7'd100;
  localparam logic [PeriodWidth-1:0] TickCountMax = 16'hFFFF;

  typedef struct packed {
    cmd_t                command;
    logic                event_active;
    logic [PctWidth-1:0] battery_pct;
  } req_t;

  typedef struct packed {
    logic                   update_flag;
    logic [PeriodWidth-1:0] gps_period;
    logic [PeriodWidth-1:0] ppg_period;
    logic [TierWidth-1:0]   power_tier;
    logic [PctWidth-1:0]    battery_level;
  } rsp_t;

  typedef struct packed {
    logic [PctWidth-1:0]    batt_high_threshold;
    logic [PctWidth-1:0]    batt_med_threshold;
    logic [PeriodWidth-1:0] gps_period_high;
    logic [PeriodWidth-1:0] gps_period_med;
    logic [PeriodWidth-1:0] gps_period_low;
    logic [PeriodWidth-1:0] ppg_period_high;
    logic [PeriodWidth-1:0] ppg_period_low;
    logic [PeriodWidth-1:0] evaluation_period;
  } cfg_t;

  // Settings chosen by one evaluation.
  typedef struct packed {
    logic [PeriodWidth-1:0] gps;
    logic [PeriodWidth-1:0] ppg;
    logic [TierWidth-1:0]   tier;
  } setting_t;

endpackage

/* src/btrg_tier_sel.sv */
module btrg_tier_sel #(
  parameter int unsigned GPS_MIN_PERIOD = btrg_pkg::GpsMinPeriodDefault,
  parameter int unsigned PPG_MAX_PERIOD = btrg_pkg::PpgMaxPeriodDefault
) (
  input  btrg_pkg::cfg_t                      cfg,
  input  logic [btrg_pkg::PctWidth-1:0]       pct,
  output btrg_pkg::setting_t                  pick
);
  import btrg_pkg::*;

  localparam logic [PeriodWidth-1:0] GpsMin = PeriodWidth'(GPS_MIN_PERIOD);
  localparam logic [PeriodWidth-1:0] PpgMax = PeriodWidth'(PPG_MAX_PERIOD);

  logic [PeriodWidth-1:0] gps_raw;
  logic [PeriodWidth-1:0] ppg_raw;
  logic [TierWidth-1:0]   tier;

  // Pick the tier against the two thresholds.
  always_comb begin
    priority if (pct > cfg.batt_high_threshold) begin
      tier    = TierHigh;
      gps_raw = cfg.gps_period_high;
      ppg_raw = cfg.ppg_period_high;
    end else if (pct > cfg.batt_med_threshold) begin
      tier    = TierMed;
      gps_raw = cfg.gps_period_med;
      ppg_raw = cfg.ppg_period_low;
    end else begin
      tier    = TierLow;
      gps_raw = cfg.gps_period_low;
      ppg_raw = cfg.ppg_period_low;
    end
  end

  // Clamp GPS from below and PPG from above.
  always_comb begin
    pick.tier = tier;
    pick.gps  = (gps_raw < GpsMin) ? GpsMin : gps_raw;
    pick.ppg  = (ppg_raw > PpgMax) ? PpgMax : ppg_raw;
  end

endmodule

/* src/battery_tier_rate_governor_top.sv */
// Battery tier rate governor. Takes one request word per cycle (tick,
// force-evaluation or event-mode command) and returns exactly one response
// word for each, in the cycle after it is accepted, from a single output
// register. Throughput is one word per cycle: the request side is stalled
// only while that output register holds a word the response side is
// stalling. Configuration writes take effect at the clock edge of the write.
module battery_tier_rate_governor_top #(
  parameter int unsigned GPS_MIN_PERIOD = btrg_pkg::GpsMinPeriodDefault,
  parameter int unsigned PPG_MAX_PERIOD = btrg_pkg::PpgMaxPeriodDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  btrg_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output btrg_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  btrg_pkg::reg_index_t               cfg_index,
  input  logic [btrg_pkg::CfgDataWidth-1:0]  cfg_data
);
  import btrg_pkg::*;

  cfg_t                   cfg;
  logic [PeriodWidth-1:0] tick_count;
  logic [PeriodWidth-1:0] tick_count_next;
  logic                   event_on;
  logic                   event_on_next;
  logic                   change_pending;
  logic                   change_pending_next;
  setting_t               cur;
  setting_t               cur_next;
  logic [PctWidth-1:0]    cur_level;
  logic [PctWidth-1:0]    cur_level_next;
  setting_t               saved;
  logic [PctWidth-1:0]    saved_level;
  logic                   save_en;
  logic                   update_flag;
  logic                   accept;
  logic [PeriodWidth-1:0] tick_inc;
  setting_t               pick;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batt_high_threshold <= RstBattHigh;
      cfg.batt_med_threshold  <= RstBattMed;
      cfg.gps_period_high     <= RstGpsHigh;
      cfg.gps_period_med      <= RstGpsMed;
      cfg.gps_period_low      <= RstGpsLow;
      cfg.ppg_period_high     <= RstPpgHigh;
      cfg.ppg_period_low      <= RstPpgLow;
      cfg.evaluation_period   <= RstEvalPer;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATT_HIGH_THRESHOLD: cfg.batt_high_threshold <= cfg_data[PctWidth-1:0];
        REG_BATT_MED_THRESHOLD:  cfg.batt_med_threshold  <= cfg_data[PctWidth-1:0];
        REG_GPS_PERIOD_HIGH:     cfg.gps_period_high     <= cfg_data[PeriodWidth-1:0];
        REG_GPS_PERIOD_MED:      cfg.gps_period_med      <= cfg_data[PeriodWidth-1:0];
        REG_GPS_PERIOD_LOW:      cfg.gps_period_low      <= cfg_data[PeriodWidth-1:0];
        REG_PPG_PERIOD_HIGH:     cfg.ppg_period_high     <= cfg_data[PeriodWidth-1:0];
        REG_PPG_PERIOD_LOW:      cfg.ppg_period_low      <= cfg_data[PeriodWidth-1:0];
        REG_EVALUATION_PERIOD:   cfg.evaluation_period   <= cfg_data[PeriodWidth-1:0];
      endcase
    end
  end

  btrg_tier_sel #(
    .GPS_MIN_PERIOD(GPS_MIN_PERIOD),
    .PPG_MAX_PERIOD(PPG_MAX_PERIOD)
  ) u_tier_sel (
    .cfg  (cfg),
    .pct  (req.battery_pct),
    .pick (pick)
  );

  // Saturating tick increment.
  assign tick_inc = (tick_count == TickCountMax) ? tick_count
                                                 : tick_count + PeriodWidth'(1);

  // Decode one request word into the next state and the update flag.
  always_comb begin
    tick_count_next     = tick_count;
    event_on_next       = event_on;
    change_pending_next = change_pending;
    cur_next            = cur;
    cur_level_next      = cur_level;
    save_en             = 1'b0;
    update_flag         = 1'b0;
    unique case (req.command)
      CMD_TICK: begin
        tick_count_next = tick_inc;
        if (event_on) begin
          if (change_pending) begin
            change_pending_next = 1'b0;
            update_flag         = 1'b1;
          end
        end else if (tick_inc >= cfg.evaluation_period) begin
          tick_count_next = '0;
          if (pick != cur) begin
            cur_next            = pick;
            cur_level_next      = req.battery_pct;
            change_pending_next = 1'b1;
            update_flag         = 1'b1;
          end
        end
      end
      CMD_FORCE_EVAL: begin
        tick_count_next = cfg.evaluation_period;
      end
      CMD_EVENT: begin
        if (req.event_active && !event_on) begin
          save_en       = 1'b1;
          cur_next.gps  = cfg.gps_period_high;
          cur_next.ppg  = cfg.ppg_period_high;
          cur_next.tier = TierHigh;
          event_on_next = 1'b1;
        end else if (!req.event_active && event_on) begin
          cur_next       = saved;
          cur_level_next = saved_level;
          event_on_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance governor state on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      event_on       <= 1'b0;
      change_pending <= 1'b0;
      cur.gps        <= RstGpsHigh;
      cur.ppg        <= RstPpgHigh;
      cur.tier       <= TierHigh;
      cur_level      <= RstLevel;
    end else if (accept) begin
      tick_count     <= tick_count_next;
      event_on       <= event_on_next;
      change_pending <= change_pending_next;
      cur            <= cur_next;
      cur_level      <= cur_level_next;
    end
  end

  // Hold the settings saved on entry to event mode.
  always_ff @(posedge clk) begin
    if (accept && save_en) begin
      saved       <= cur;
      saved_level <= cur_level;
    end
  end

  // Output register: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.update_flag   <= update_flag;
      rsp.gps_period    <= cur_next.gps;
      rsp.ppg_period    <= cur_next.ppg;
      rsp.power_tier    <= cur_next.tier;
      rsp.battery_level <= cur_level_next;
    end
  end

endmodule

/* src/btrg_checker.sv */
`include "battery_tier_rate_governor_top_defines.svh"

module btrg_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input btrg_pkg::rsp_t rsp
);
  import btrg_pkg::*;

  // A held response word keeps its contents.
  `BTRG_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Requests stall only behind a stalled, full output register.
  `BTRG_ASSERT_NOW(a_stall_cause, clk, rst, req_stall, rsp_valid && rsp_stall)

  // Every accepted request word produces a response word next cycle.
  `BTRG_ASSERT_NEXT(a_rsp_follows, clk, rst, req_valid && !req_stall, rsp_valid)

  // Reported tier is always a real tier code.
  `BTRG_ASSERT_NOW(a_tier_code, clk, rst, rsp_valid, rsp.power_tier <= TierLow)

endmodule

bind battery_tier_rate_governor_top btrg_checker u_btrg_checker (.*);

/* tb/tb_battery_tier_rate_governor_top.sv */
`timescale 1ns / 1ps

module tb_battery_tier_rate_governor_top;
  import btrg_pkg::*;

  // Command code 3 has no meaning; the block must treat it as a no-op.
  localparam cmd_t CmdUnused = cmd_t'(2'd3);
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned WordsPerPhase = 190;

  // Tracks the governor state and holds the response words still owed.
  class governor_checker;
    cfg_t                   regs;
    logic [PeriodWidth-1:0] tick_count;
    bit                     in_event;
    bit                     change_pending;
    setting_t               live;
    setting_t               saved;
    logic [PctWidth-1:0]    live_level;
    logic [PctWidth-1:0]    saved_level;
    rsp_t                   expected_words[$];
    int                     errors;

    function new();
      regs = '{batt_high_threshold: RstBattHigh, batt_med_threshold: RstBattMed,
               gps_period_high: RstGpsHigh, gps_period_med: RstGpsMed,
               gps_period_low: RstGpsLow, ppg_period_high: RstPpgHigh,
               ppg_period_low: RstPpgLow, evaluation_period: RstEvalPer};
      tick_count     = '0;
      in_event       = 1'b0;
      change_pending = 1'b0;
      live           = '{gps: RstGpsHigh, ppg: RstPpgHigh, tier: TierHigh};
      saved          = '0;
      live_level     = RstLevel;
      saved_level    = '0;
      errors         = 0;
    endfunction

    // Pick the tier for a battery level and clamp its periods.
    function setting_t tier_setting(logic [PctWidth-1:0] pct);
      setting_t s;
      if (pct > regs.batt_high_threshold) begin
        s = '{gps: regs.gps_period_high, ppg: regs.ppg_period_high, tier: TierHigh};
      end else if (pct > regs.batt_med_threshold) begin
        s = '{gps: regs.gps_period_med, ppg: regs.ppg_period_low, tier: TierMed};
      end else begin
        s = '{gps: regs.gps_period_low, ppg: regs.ppg_period_low, tier: TierLow};
      end
      if (s.gps < GpsMinPeriodDefault) s.gps = PeriodWidth'(GpsMinPeriodDefault);
      if (s.ppg > PpgMaxPeriodDefault) s.ppg = PeriodWidth'(PpgMaxPeriodDefault);
      return s;
    endfunction

    // Advance the state for one accepted request word and queue its response.
    function void note_request(req_t w);
      setting_t s;
      logic     flag;
      flag = 1'b0;
      case (w.command)
        CMD_TICK: begin
          if (tick_count != TickCountMax) tick_count++;
          if (in_event) begin
            // report a pending change once, never evaluate
            if (change_pending) begin
              change_pending = 1'b0;
              flag = 1'b1;
            end
          end else if (tick_count >= regs.evaluation_period) begin
            tick_count = '0;
            s = tier_setting(w.battery_pct);
            if (s != live) begin
              live = s;
              live_level = w.battery_pct;
              change_pending = 1'b1;
              flag = 1'b1;
            end
          end
        end
        CMD_FORCE_EVAL: begin
          tick_count = regs.evaluation_period;
        end
        CMD_EVENT: begin
          if (w.event_active && !in_event) begin
            // save, then force the unclamped high-battery periods
            saved = live;
            saved_level = live_level;
            live = '{gps: regs.gps_period_high, ppg: regs.ppg_period_high, tier: TierHigh};
            in_event = 1'b1;
          end else if (!w.event_active && in_event) begin
            live = saved;
            live_level = saved_level;
            in_event = 1'b0;
          end
        end
        default: ;
      endcase
      expected_words.push_back('{update_flag: flag, gps_period: live.gps,
                                 ppg_period: live.ppg, power_tier: live.tier,
                                 battery_level: live_level});
    endfunction

    // Compare one accepted response word with the oldest expected one.
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response word %p", got);
        return;
      end
      want = expected_words.pop_front();
      if (got.update_flag !== want.update_flag || got.gps_period !== want.gps_period ||
          got.ppg_period !== want.ppg_period || got.power_tier !== want.power_tier ||
          got.battery_level !== want.battery_level) begin
        errors++;
        if (errors <= 10) begin
          $display("response mismatch: expected flag %0d gps %0d ppg %0d tier %0d level %0d",
                   want.update_flag, want.gps_period, want.ppg_period, want.power_tier,
                   want.battery_level);
          $display("                   got      flag %0d gps %0d ppg %0d tier %0d level %0d",
                   got.update_flag, got.gps_period, got.ppg_period, got.power_tier,
                   got.battery_level);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  req_t                    req = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  rsp_t                    rsp;
  logic                    cfg_we = 1'b0;
  reg_index_t              cfg_index = REG_BATT_HIGH_THRESHOLD;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  governor_checker sb;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;

  battery_tier_rate_governor_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the response side at random.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // Note accepted request words and check accepted response words.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  // Offer one request word, idling first at random, and hold it until taken.
  task automatic push_word(input cmd_t c, input logic act, input logic [PctWidth-1:0] pct);
    while ($urandom_range(99, 0) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{command: c, event_active: act, battery_pct: pct};
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every expected response word has come.
  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Write all registers back to back; upper data bits of the narrow ones are junk.
  task automatic apply_setting(input cfg_t c);
    reg_index_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_index_t'(i);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_BATT_HIGH_THRESHOLD: cfg_data <= {9'($urandom), c.batt_high_threshold};
        REG_BATT_MED_THRESHOLD:  cfg_data <= {9'($urandom), c.batt_med_threshold};
        REG_GPS_PERIOD_HIGH:     cfg_data <= c.gps_period_high;
        REG_GPS_PERIOD_MED:      cfg_data <= c.gps_period_med;
        REG_GPS_PERIOD_LOW:      cfg_data <= c.gps_period_low;
        REG_PPG_PERIOD_HIGH:     cfg_data <= c.ppg_period_high;
        REG_PPG_PERIOD_LOW:      cfg_data <= c.ppg_period_low;
        default:                 cfg_data <= c.evaluation_period;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.regs = c;
  endtask

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    cfg_t                setting;
    int unsigned         r;
    cmd_t                c;
    logic                act;
    logic [PctWidth-1:0] pct;

    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: thresholds at and past their edges,
    // redundant event commands, pending report in event mode, no-op code.
    push_word(CMD_TICK, 1'b0, 7'd127);
    push_word(CmdUnused, 1'b1, 7'd127);
    push_word(CMD_FORCE_EVAL, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd0);
    push_word(CMD_FORCE_EVAL, 1'b1, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd20);
    push_word(CMD_FORCE_EVAL, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd21);
    push_word(CMD_FORCE_EVAL, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b1, 7'd60);
    push_word(CMD_FORCE_EVAL, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd61);
    push_word(CMD_EVENT, 1'b0, 7'd5);
    push_word(CMD_EVENT, 1'b1, 7'd5);
    push_word(CMD_EVENT, 1'b1, 7'd90);
    push_word(CMD_TICK, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd0);
    push_word(CMD_FORCE_EVAL, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd0);
    push_word(CMD_EVENT, 1'b0, 7'd0);
    push_word(CMD_FORCE_EVAL, 1'b0, 7'd0);
    push_word(CMD_TICK, 1'b0, 7'd100);
    drain_responses();

    // Random phases: idling mix per group of three, new settings after phase 0.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      gap_pct   = (phase < 3) ? 38 : (phase < 6) ? 77 : 0;
      stall_pct = (phase < 3) ? 77 : (phase < 6) ? 38 : 0;
      if (phase != 0) begin
        drain_responses();
        case (phase)
          1: setting = '{batt_high_threshold: 50, batt_med_threshold: 25,
                         gps_period_high: 3, gps_period_med: 0, gps_period_low: 0,
                         ppg_period_high: 4000, ppg_period_low: 3601,
                         evaluation_period: 1};
          2: setting = '0;
          3: setting = '1;
          4: setting = '{batt_high_threshold: 100, batt_med_threshold: 0,
                         gps_period_high: 0, gps_period_med: 1, gps_period_low: 2,
                         ppg_period_high: 16'hFFFF, ppg_period_low: 3600,
                         evaluation_period: 2};
          6: setting = '{batt_high_threshold: 30, batt_med_threshold: 80,
                         gps_period_high: 5, gps_period_med: 6, gps_period_low: 7,
                         ppg_period_high: 8, ppg_period_low: 9,
                         evaluation_period: 3};
          8: setting = '{batt_high_threshold: RstBattHigh, batt_med_threshold: RstBattMed,
                         gps_period_high: RstGpsHigh, gps_period_med: RstGpsMed,
                         gps_period_low: RstGpsLow, ppg_period_high: RstPpgHigh,
                         ppg_period_low: RstPpgLow, evaluation_period: RstEvalPer};
          default: begin
            setting.batt_high_threshold = 7'($urandom);
            setting.batt_med_threshold  = 7'($urandom);
            setting.gps_period_high     = 16'($urandom);
            setting.gps_period_med      = 16'($urandom_range(3, 0));
            setting.gps_period_low      = 16'($urandom);
            setting.ppg_period_high     = 16'($urandom);
            setting.ppg_period_low      = 16'($urandom_range(3610, 3590));
            setting.evaluation_period   = (phase == 5) ? 16'($urandom_range(4, 0))
                                                       : 16'($urandom);
          end
        endcase
        apply_setting(setting);
      end

      for (int n = 0; n < WordsPerPhase; n++) begin
        // mostly ticks, with enough forced evaluations and event toggles to
        // keep the tier moving
        r = $urandom_range(99, 0);
        c = (r < 55) ? CMD_TICK : (r < 70) ? CMD_FORCE_EVAL : (r < 93) ? CMD_EVENT
                                                            : CmdUnused;
        act = 1'($urandom);
        r = $urandom_range(9, 0);
        if (r < 3) begin
          pct = sb.regs.batt_high_threshold + 7'($urandom_range(2, 0)) - 7'd1;
        end else if (r < 6) begin
          pct = sb.regs.batt_med_threshold + 7'($urandom_range(2, 0)) - 7'd1;
        end else begin
          pct = 7'($urandom);
        end
        push_word(c, act, pct);
        // hold the sender until the response side has caught up
        if (phase == 1 && n == WordsPerPhase / 2) drain_responses();
      end
    end

    drain_responses();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
